@@ design/pwm_period_and_compare_calculator_defines.svh @@
// assertion macros for the pwm period and compare calculator
`ifndef PWM_PERIOD_AND_COMPARE_CALCULATOR_DEFINES_SVH
`define PWM_PERIOD_AND_COMPARE_CALCULATOR_DEFINES_SVH

// condition a implies condition b in the same cycle
`define PWMC_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("pwmc check failed");

// condition a implies condition b in the next cycle
`define PWMC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("pwmc check failed");

`endif

@@ design/pwmc_pkg.sv @@
// shared constants and types of the pwm period and compare calculator
`timescale 1ns / 1ps

package pwmc_pkg;

    localparam int CLK_W  = 27;
    localparam int FREQ_W = 24;
    localparam int DUTY_W = 7;
    localparam int DIV_W  = 26;
    localparam int Q_W    = 17;
    localparam int PROD_W = 24;

    // config register indexes
    localparam logic [1:0] REG_CLOCK_HZ      = 2'd0;
    localparam logic [1:0] REG_WAVEFORM_MODE = 2'd1;
    localparam logic [1:0] REG_INVERT_OUTPUT = 2'd2;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 27'd8000000;

    // prescaler codes
    localparam logic [1:0] CS_DIV1  = 2'd1;
    localparam logic [1:0] CS_DIV8  = 2'd2;
    localparam logic [1:0] CS_DIV64 = 2'd3;

    // compare output modes
    localparam logic [1:0] OM_NONINV = 2'd2;
    localparam logic [1:0] OM_INV    = 2'd3;

    // error codes
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_SAT  = 2'd2;
    localparam logic [1:0] ERR_HIGH = 2'd3;

    // prescaler thresholds
    localparam logic [FREQ_W-1:0] FAST_LIM64 = 24'd1000;
    localparam logic [FREQ_W-1:0] FAST_LIM8  = 24'd10000;
    localparam logic [FREQ_W-1:0] PC_LIM64   = 24'd500;
    localparam logic [FREQ_W-1:0] PC_LIM8    = 24'd5000;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    // floor(x / 100) = (x * RECIP100) >> RECIP_SHIFT for x below 2^23
    localparam logic [23:0] RECIP100    = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;

    // one item inside the divider pipeline
    typedef struct packed {
        logic              valid;
        logic              chan;
        logic [DUTY_W-1:0] duty;
        logic              phase;
        logic              inv;
        logic [1:0]        sel;
        logic              zero;
        logic              ovf;
        logic [DIV_W-1:0]  divisor;
        logic [CLK_W-1:0]  dividend;
        logic [DIV_W-1:0]  rem;
        logic [Q_W-1:0]    quo;
    } t_div;

    // one finished result
    typedef struct packed {
        logic        valid;
        logic        channel_out;
        logic [1:0]  clock_select;
        logic [15:0] top_value;
        logic [15:0] compare_value;
        logic [1:0]  output_mode;
        logic [1:0]  error_code;
    } t_res;

endpackage

@@ design/pwmc_ifs.sv @@
// handshake interfaces for requests, results and config writes
`timescale 1ns / 1ps

interface pwmc_req_if;
    logic        valid;
    logic        ready;
    logic        channel;
    logic [6:0]  duty_percent;
    logic [23:0] frequency_hz;
    modport source (output valid, channel, duty_percent, frequency_hz, input ready);
    modport sink   (input valid, channel, duty_percent, frequency_hz, output ready);
endinterface

interface pwmc_res_if;
    logic        valid;
    logic        ready;
    logic        channel_out;
    logic [1:0]  clock_select;
    logic [15:0] top_value;
    logic [15:0] compare_value;
    logic [1:0]  output_mode;
    logic [1:0]  error_code;
    modport source (output valid, channel_out, clock_select, top_value, compare_value,
                    output_mode, error_code, input ready);
    modport sink   (input valid, channel_out, clock_select, top_value, compare_value,
                    output_mode, error_code, output ready);
endinterface

interface pwmc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [26:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/pwmc_div_stage.sv @@
// one restoring division step of the quotient pipeline
`timescale 1ns / 1ps

module pwmc_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_bit,
    input  pwmc_pkg::t_div i_d,
    output pwmc_pkg::t_div o_d
);

    pwmc_pkg::t_div      r_d;
    pwmc_pkg::t_div      n_d;
    logic [pwmc_pkg::DIV_W:0] w_trial;
    logic                w_ge;

    // bring down the next dividend bit and try to subtract
    always_comb begin
        w_trial = {i_d.rem, i_bit};
        w_ge    = w_trial >= {1'b0, i_d.divisor};
        n_d     = i_d;
        if (w_ge) begin
            n_d.rem = pwmc_pkg::DIV_W'(w_trial - {1'b0, i_d.divisor});
        end else begin
            n_d.rem = w_trial[pwmc_pkg::DIV_W-1:0];
        end
        n_d.quo = {i_d.quo[pwmc_pkg::Q_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= n_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d.chan     <= n_d.chan;
            r_d.duty     <= n_d.duty;
            r_d.phase    <= n_d.phase;
            r_d.inv      <= n_d.inv;
            r_d.sel      <= n_d.sel;
            r_d.zero     <= n_d.zero;
            r_d.ovf      <= n_d.ovf;
            r_d.divisor  <= n_d.divisor;
            r_d.dividend <= n_d.dividend;
            r_d.rem      <= n_d.rem;
            r_d.quo      <= n_d.quo;
        end
    end

    assign o_d = r_d;

endmodule

@@ design/pwmc_cmp_calc.sv @@
// top saturation, duty multiply and divide by 100, three stages
`timescale 1ns / 1ps

module pwmc_cmp_calc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  pwmc_pkg::t_div i_d,
    output pwmc_pkg::t_res o_res
);

    // stage a: top and product
    logic        r_a_valid, r_a_chan, r_a_inv;
    logic [1:0]  r_a_sel, r_a_err;
    logic [15:0] r_a_top;
    logic [pwmc_pkg::PROD_W-1:0] r_a_prod;
    // stage b: reciprocal product
    logic        r_b_valid, r_b_chan, r_b_inv;
    logic [1:0]  r_b_sel, r_b_err;
    logic [15:0] r_b_top;
    logic [47:0] r_b_big;
    // stage c: output register
    pwmc_pkg::t_res r_res;

    logic [15:0] n_top;
    logic [1:0]  n_err;
    logic [16:0] w_mul;
    logic [17:0] w_cq;
    logic [15:0] n_cmp;
    logic [1:0]  n_err_c;

    // turn the quotient into a saturated top value
    always_comb begin
        n_top = 16'd0;
        n_err = pwmc_pkg::ERR_OK;
        if (i_d.zero) begin
            n_top = pwmc_pkg::SAT16;
            n_err = pwmc_pkg::ERR_ZERO;
        end else if (i_d.phase) begin
            if (i_d.ovf || i_d.quo[16]) begin
                n_top = pwmc_pkg::SAT16;
                n_err = pwmc_pkg::ERR_SAT;
            end else begin
                n_top = i_d.quo[15:0];
            end
        end else begin
            if (i_d.ovf || (i_d.quo > 17'd65536)) begin
                n_top = pwmc_pkg::SAT16;
                n_err = pwmc_pkg::ERR_SAT;
            end else if (i_d.quo == 17'd0) begin
                n_top = 16'd0;
                n_err = pwmc_pkg::ERR_HIGH;
            end else begin
                n_top = 16'(i_d.quo - 17'd1);
            end
        end
        w_mul = i_d.phase ? {1'b0, n_top} : ({1'b0, n_top} + 17'd1);
    end

    // divide by 100 result and compare saturation
    always_comb begin
        w_cq    = r_b_big[47:pwmc_pkg::RECIP_SHIFT];
        n_err_c = r_b_err;
        if (w_cq[17:16] != 2'd0) begin
            n_cmp = pwmc_pkg::SAT16;
            if (r_b_err == pwmc_pkg::ERR_OK) begin
                n_err_c = pwmc_pkg::ERR_SAT;
            end
        end else begin
            n_cmp = w_cq[15:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid   <= i_d.valid;
            r_b_valid   <= r_a_valid;
            r_res.valid <= r_b_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_chan <= i_d.chan;
            r_a_inv  <= i_d.inv;
            r_a_sel  <= i_d.sel;
            r_a_err  <= n_err;
            r_a_top  <= n_top;
            r_a_prod <= pwmc_pkg::PROD_W'(i_d.duty * w_mul);

            r_b_chan <= r_a_chan;
            r_b_inv  <= r_a_inv;
            r_b_sel  <= r_a_sel;
            r_b_err  <= r_a_err;
            r_b_top  <= r_a_top;
            r_b_big  <= r_a_prod * pwmc_pkg::RECIP100;

            r_res.channel_out   <= r_b_chan;
            r_res.clock_select  <= r_b_sel;
            r_res.top_value     <= r_b_top;
            r_res.compare_value <= n_cmp;
            r_res.output_mode   <= r_b_inv ? pwmc_pkg::OM_INV : pwmc_pkg::OM_NONINV;
            r_res.error_code    <= n_err_c;
        end
    end

    assign o_res = r_res;

endmodule

@@ design/pwm_period_and_compare_calculator.sv @@
// top level: config registers, prescaler select, divider pipeline, compare calc
// pipeline: 21 register stages, from the entry register through the quotient steps to the compare calc
// throughput: one request per cycle; the whole pipeline advances together
// and holds while a finished result waits at the output register
// the 17 quotient bits come from a chain of one restoring step per stage
// reset (synchronous, active low) empties the pipeline and restores config defaults
`timescale 1ns / 1ps
`include "pwm_period_and_compare_calculator_defines.svh"

module pwm_period_and_compare_calculator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pwmc_req_if.sink   i_req,
    pwmc_cfg_if.sink   i_cfg,
    pwmc_res_if.source o_res
);

    logic [pwmc_pkg::CLK_W-1:0] r_clock_hz;
    logic                       r_mode;
    logic                       r_inv;

    logic           w_en;
    logic [1:0]     w_sel;
    logic [2:0]     w_sh;
    pwmc_pkg::t_div n_s0;
    pwmc_pkg::t_div r_s0;
    pwmc_pkg::t_div w_div [0:pwmc_pkg::Q_W];
    pwmc_pkg::t_res w_res;

    assign i_cfg.ready = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= pwmc_pkg::CLOCK_HZ_RESET;
            r_mode     <= 1'b0;
            r_inv      <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pwmc_pkg::REG_CLOCK_HZ:      r_clock_hz <= i_cfg.data;
                pwmc_pkg::REG_WAVEFORM_MODE: r_mode     <= i_cfg.data[0];
                pwmc_pkg::REG_INVERT_OUTPUT: r_inv      <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // global advance
    assign w_en        = !w_res.valid || o_res.ready;
    assign i_req.ready = w_en;

    // prescaler select and divisor build
    always_comb begin
        if (r_mode) begin
            if (i_req.frequency_hz <= pwmc_pkg::PC_LIM64) begin
                w_sel = pwmc_pkg::CS_DIV64;
                w_sh  = 3'd7;
            end else if (i_req.frequency_hz < pwmc_pkg::PC_LIM8) begin
                w_sel = pwmc_pkg::CS_DIV8;
                w_sh  = 3'd4;
            end else begin
                w_sel = pwmc_pkg::CS_DIV1;
                w_sh  = 3'd1;
            end
        end else begin
            if (i_req.frequency_hz <= pwmc_pkg::FAST_LIM64) begin
                w_sel = pwmc_pkg::CS_DIV64;
                w_sh  = 3'd6;
            end else if (i_req.frequency_hz < pwmc_pkg::FAST_LIM8) begin
                w_sel = pwmc_pkg::CS_DIV8;
                w_sh  = 3'd3;
            end else begin
                w_sel = pwmc_pkg::CS_DIV1;
                w_sh  = 3'd0;
            end
        end
        n_s0.valid    = i_req.valid;
        n_s0.chan     = i_req.channel;
        n_s0.duty     = i_req.duty_percent;
        n_s0.phase    = r_mode;
        n_s0.inv      = r_inv;
        n_s0.sel      = w_sel;
        n_s0.zero     = i_req.frequency_hz == 24'd0;
        n_s0.divisor  = pwmc_pkg::DIV_W'(i_req.frequency_hz) << w_sh;
        n_s0.dividend = r_clock_hz;
        // quotient of 2^17 or more saturates in every mode
        n_s0.ovf      = {16'd0, r_clock_hz[26:17]} >= n_s0.divisor;
        n_s0.rem      = {16'd0, r_clock_hz[26:17]};
        n_s0.quo      = '0;
    end

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_en) begin
            r_s0.valid <= n_s0.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0.chan     <= n_s0.chan;
            r_s0.duty     <= n_s0.duty;
            r_s0.phase    <= n_s0.phase;
            r_s0.inv      <= n_s0.inv;
            r_s0.sel      <= n_s0.sel;
            r_s0.zero     <= n_s0.zero;
            r_s0.ovf      <= n_s0.ovf;
            r_s0.divisor  <= n_s0.divisor;
            r_s0.dividend <= n_s0.dividend;
            r_s0.rem      <= n_s0.rem;
            r_s0.quo      <= n_s0.quo;
        end
    end

    assign w_div[0] = r_s0;

    // quotient pipeline, msb first
    for (genvar k = 0; k < pwmc_pkg::Q_W; k++) begin : g_div
        pwmc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bit   (w_div[k].dividend[pwmc_pkg::Q_W-1-k]),
            .i_d     (w_div[k]),
            .o_d     (w_div[k+1])
        );
    end

    pwmc_cmp_calc u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_d     (w_div[pwmc_pkg::Q_W]),
        .o_res   (w_res)
    );

    assign o_res.valid         = w_res.valid;
    assign o_res.channel_out   = w_res.channel_out;
    assign o_res.clock_select  = w_res.clock_select;
    assign o_res.top_value     = w_res.top_value;
    assign o_res.compare_value = w_res.compare_value;
    assign o_res.output_mode   = w_res.output_mode;
    assign o_res.error_code    = w_res.error_code;

    // checks
    `PWMC_ASSERT_NOW(a_zero_sat, i_clk, i_rst_n,
        o_res.valid && (o_res.error_code == pwmc_pkg::ERR_ZERO),
        (o_res.top_value == pwmc_pkg::SAT16) && (o_res.clock_select == pwmc_pkg::CS_DIV64))
    `PWMC_ASSERT_NOW(a_high_top0, i_clk, i_rst_n,
        o_res.valid && (o_res.error_code == pwmc_pkg::ERR_HIGH),
        o_res.top_value == 16'd0)
    `PWMC_ASSERT_NOW(a_sel_legal, i_clk, i_rst_n,
        o_res.valid, o_res.clock_select != 2'd0)
    `PWMC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.top_value))

endmodule
